### rtl/jet_pkg.sv
// jet_pkg: shared types, codes and character constants of the json event tokenizer
// used by every module of the block and by the port checker
package jet_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int OFFSET_BITS_DEF = 24;
   localparam int FIELD_W         = 24;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;

   typedef enum logic [1:0] {
      CTX_OBJECT = 2'd0,
      CTX_ARRAY  = 2'd1,
      CTX_VALUE  = 2'd2,
      CTX_NONE   = 2'd3
   } ctx_type;

   typedef enum logic [3:0] {
      MODE_NORMAL     = 4'd0,
      MODE_SLASH      = 4'd1,
      MODE_LINE       = 4'd2,
      MODE_BLOCK      = 4'd3,
      MODE_BLOCK_STAR = 4'd4,
      MODE_STRING     = 4'd5,
      MODE_ESCAPE     = 4'd6,
      MODE_BARE       = 4'd7,
      MODE_FINISHED   = 4'd8
   } mode_type;

   typedef enum logic [2:0] {
      EV_BEGIN_OBJECT = 3'd0,
      EV_END_OBJECT   = 3'd1,
      EV_BEGIN_ARRAY  = 3'd2,
      EV_END_ARRAY    = 3'd3,
      EV_KEY          = 3'd4,
      EV_VALUE        = 3'd5,
      EV_DONE         = 3'd6,
      EV_ERROR        = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_MISMATCH     = 2'd1,
      ERR_UNTERMINATED = 2'd2,
      ERR_OVERFLOW     = 2'd3
   } error_type;

   typedef struct packed {
      event_type          event_res;
      error_type          error_kind;
      logic [FIELD_W-1:0] text_start;
      logic [FIELD_W-1:0] text_length;
      logic               last_of_run;
   } rsp_item_type;

   // results of one request, in order, as written into the result queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } event_pair_type;

endpackage

### rtl/jet_req_if.sv
// jet_req_if: request channel of the tokenizer, one text byte or an end mark
// standalone, no package dependency
interface jet_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

### rtl/jet_rsp_if.sv
// jet_rsp_if: result channel of the tokenizer, one event per handshake
// standalone, no package dependency
interface jet_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [1:0]  error_kind;
   logic [23:0] text_start;
   logic [23:0] text_length;
   logic        last_of_run;

   modport source (output valid, output event_res, output error_kind, output text_start,
                   output text_length, output last_of_run, input ready);
   modport sink (input valid, input event_res, input error_kind, input text_start,
                 input text_length, input last_of_run, output ready);
endinterface

### rtl/jet_core.sv
// jet_core: request register, scan state, context stack and the one-pass step logic
// depends on jet_pkg and jet_req_if
module jet_core #(
   parameter int STACK_DEPTH = jet_pkg::STACK_DEPTH_DEF,
   parameter int OFFSET_BITS = jet_pkg::OFFSET_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   jet_req_if.sink                 req,
   input  logic                    room,
   output jet_pkg::event_pair_type wr_out
);
   import jet_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SLOTS = (STACK_DEPTH < 4) ? 4 : STACK_DEPTH;
   localparam logic [OFFSET_BITS-1:0] LEN_MAX = '1;

   // request register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       eot_ff;
   logic       accept, fire;

   // scan state
   mode_type               mode_ff, mode_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [OFFSET_BITS-1:0] bp_ff, bp_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] len_ff, len_in;
   ctx_type                stk_ff [SLOTS];
   ctx_type                stk_in [SLOTS];
   ctx_type [3:0]          view;

   // step controls
   logic [1:0]             pops;
   logic                   push_en;
   ctx_type                push_val;
   logic                   do_normal;
   logic                   pre_en;
   logic                   main_en;
   event_type              main_ev;
   error_type              main_err;
   logic [OFFSET_BITS:0]   len_plus1, len_plus2;

   function automatic ctx_type top_at(input logic [CNT_W-1:0] cnt, input ctx_type [3:0] v,
                                      input logic [1:0] p);
      top_at = (cnt > CNT_W'(p)) ? v[p] : CTX_NONE;
   endfunction

   function automatic logic [FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] x);
      logic [31:0] wide;
      wide = 32'(x);
      to_field = wide[FIELD_W-1:0];
   endfunction

   function automatic rsp_item_type make_item(input event_type ev, input error_type err,
                                              input logic [OFFSET_BITS-1:0] s,
                                              input logic [OFFSET_BITS-1:0] l,
                                              input logic last);
      rsp_item_type it;
      it.event_res   = ev;
      it.error_kind  = err;
      it.last_of_run = last;
      if (ev == EV_KEY || ev == EV_VALUE) begin
         it.text_start  = to_field(s);
         it.text_length = to_field(l);
      end else begin
         it.text_start  = '0;
         it.text_length = '0;
      end
      make_item = it;
   endfunction

   assign fire      = in_valid_ff && room;
   assign req.ready = !in_valid_ff || room;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req.text_byte;
         eot_ff  <= req.end_of_text;
      end
   end

   // the four entries nearest the top feed the step logic
   for (genvar k = 0; k < 4; k++) begin : g_view
      assign view[k] = stk_ff[k];
   end

   assign len_plus1 = {1'b0, len_ff} + (OFFSET_BITS + 1)'(1);
   assign len_plus2 = {1'b0, len_ff} + (OFFSET_BITS + 1)'(2);

   always_comb begin
      mode_in   = mode_ff;
      bp_in     = bp_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      pops      = 2'd0;
      push_en   = 1'b0;
      push_val  = CTX_NONE;
      do_normal = 1'b0;
      pre_en    = 1'b0;
      main_en   = 1'b0;
      main_ev   = EV_DONE;
      main_err  = ERR_NONE;

      if (fire && mode_ff != MODE_FINISHED) begin
         if (eot_ff) begin
            case (mode_ff)
               MODE_BLOCK, MODE_BLOCK_STAR, MODE_STRING, MODE_ESCAPE: begin
                  main_en  = 1'b1;
                  main_ev  = EV_ERROR;
                  main_err = ERR_UNTERMINATED;
                  mode_in  = MODE_FINISHED;
               end
               MODE_BARE: begin
                  pre_en = 1'b1;
                  if (top_at(count_ff, view, 2'd0) == CTX_VALUE) begin
                     pops = 2'd1;
                  end
                  main_en = 1'b1;
                  main_ev = EV_DONE;
                  mode_in = MODE_FINISHED;
               end
               default: begin
                  main_en = 1'b1;
                  main_ev = EV_DONE;
                  mode_in = MODE_FINISHED;
               end
            endcase
         end else begin
            bp_in = bp_ff + OFFSET_BITS'(1);
            case (mode_ff)
               MODE_NORMAL: begin
                  do_normal = 1'b1;
               end
               MODE_SLASH: begin
                  if (byte_ff == CH_SLASH) begin
                     mode_in = MODE_LINE;
                  end else if (byte_ff == CH_STAR) begin
                     mode_in = MODE_BLOCK;
                  end else begin
                     mode_in   = MODE_NORMAL;
                     do_normal = 1'b1;
                  end
               end
               MODE_LINE: begin
                  if (byte_ff == CH_NUL) begin
                     main_en = 1'b1;
                     main_ev = EV_DONE;
                     mode_in = MODE_FINISHED;
                  end else if (byte_ff == CH_LF || byte_ff == CH_CR) begin
                     mode_in = MODE_NORMAL;
                  end
               end
               MODE_BLOCK, MODE_BLOCK_STAR: begin
                  if (mode_ff == MODE_BLOCK_STAR && byte_ff == CH_SLASH) begin
                     mode_in = MODE_NORMAL;
                  end else if (byte_ff == CH_NUL) begin
                     main_en  = 1'b1;
                     main_ev  = EV_ERROR;
                     main_err = ERR_UNTERMINATED;
                     mode_in  = MODE_FINISHED;
                  end else if (byte_ff == CH_STAR) begin
                     mode_in = MODE_BLOCK_STAR;
                  end else begin
                     mode_in = MODE_BLOCK;
                  end
               end
               MODE_STRING: begin
                  if (byte_ff == CH_NUL || byte_ff == CH_LF || byte_ff == CH_CR) begin
                     main_en  = 1'b1;
                     main_ev  = EV_ERROR;
                     main_err = ERR_UNTERMINATED;
                     mode_in  = MODE_FINISHED;
                  end else if (byte_ff == CH_BACKSLASH) begin
                     mode_in = MODE_ESCAPE;
                  end else if (byte_ff == CH_QUOTE) begin
                     mode_in = MODE_NORMAL;
                     main_en = 1'b1;
                     // a string in an array or after a colon is a value, else a key
                     if (top_at(count_ff, view, 2'd0) == CTX_ARRAY) begin
                        main_ev = EV_VALUE;
                     end else if (top_at(count_ff, view, 2'd0) == CTX_VALUE) begin
                        main_ev = EV_VALUE;
                        pops    = 2'd1;
                     end else begin
                        main_ev = EV_KEY;
                     end
                  end else begin
                     len_in = len_plus1[OFFSET_BITS] ? LEN_MAX : len_plus1[OFFSET_BITS-1:0];
                  end
               end
               MODE_ESCAPE: begin
                  len_in  = len_plus2[OFFSET_BITS] ? LEN_MAX : len_plus2[OFFSET_BITS-1:0];
                  mode_in = MODE_STRING;
               end
               MODE_BARE: begin
                  if (byte_ff == CH_COMMA || byte_ff == CH_RBRACE || byte_ff == CH_RBRACKET ||
                      byte_ff == CH_NUL || byte_ff == CH_LF || byte_ff == CH_CR) begin
                     // value ends here and the delimiter is scanned as normal text
                     pre_en = 1'b1;
                     if (top_at(count_ff, view, 2'd0) == CTX_VALUE) begin
                        pops = 2'd1;
                     end
                     mode_in   = MODE_NORMAL;
                     do_normal = 1'b1;
                  end else begin
                     len_in = len_plus1[OFFSET_BITS] ? LEN_MAX : len_plus1[OFFSET_BITS-1:0];
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase

            if (do_normal) begin
               case (byte_ff)
                  CH_NUL: begin
                     main_en = 1'b1;
                     main_ev = EV_DONE;
                     mode_in = MODE_FINISHED;
                  end
                  CH_SLASH: begin
                     mode_in = MODE_SLASH;
                  end
                  CH_HASH: begin
                     mode_in = MODE_LINE;
                  end
                  CH_LBRACE, CH_LBRACKET, CH_COLON: begin
                     main_en = 1'b1;
                     if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                        main_ev  = EV_ERROR;
                        main_err = ERR_OVERFLOW;
                        mode_in  = MODE_FINISHED;
                     end else begin
                        push_en = 1'b1;
                        if (byte_ff == CH_LBRACE) begin
                           push_val = CTX_OBJECT;
                           main_ev  = EV_BEGIN_OBJECT;
                        end else if (byte_ff == CH_LBRACKET) begin
                           push_val = CTX_ARRAY;
                           main_ev  = EV_BEGIN_ARRAY;
                        end else begin
                           push_val = CTX_VALUE;
                           main_en  = 1'b0;
                        end
                     end
                  end
                  CH_RBRACE, CH_RBRACKET: begin
                     if (top_at(count_ff, view, pops) == CTX_VALUE) begin
                        pops = pops + 2'd1;
                     end
                     main_en = 1'b1;
                     if (byte_ff == CH_RBRACE && top_at(count_ff, view, pops) == CTX_OBJECT) begin
                        pops    = pops + 2'd1;
                        main_ev = EV_END_OBJECT;
                     end else if (byte_ff == CH_RBRACKET &&
                                  top_at(count_ff, view, pops) == CTX_ARRAY) begin
                        pops    = pops + 2'd1;
                        main_ev = EV_END_ARRAY;
                     end else begin
                        main_ev  = EV_ERROR;
                        main_err = ERR_MISMATCH;
                        mode_in  = MODE_FINISHED;
                     end
                  end
                  CH_COMMA: begin
                     if (top_at(count_ff, view, pops) == CTX_VALUE) begin
                        pops = pops + 2'd1;
                     end
                  end
                  CH_QUOTE: begin
                     start_in = bp_ff + OFFSET_BITS'(1);
                     len_in   = '0;
                     mode_in  = MODE_STRING;
                  end
                  default: begin
                     if (byte_ff > CH_SPACE) begin
                        start_in = bp_ff;
                        len_in   = OFFSET_BITS'(1);
                        mode_in  = MODE_BARE;
                     end
                  end
               endcase
            end
         end
      end
   end

   // stack shifts down on a push and up by the pop count
   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      ctx_type up1, up2, up3, down;
      if (i + 1 < SLOTS) begin : g_up1
         assign up1 = stk_ff[i + 1];
      end else begin : g_up1_edge
         assign up1 = stk_ff[i];
      end
      if (i + 2 < SLOTS) begin : g_up2
         assign up2 = stk_ff[i + 2];
      end else begin : g_up2_edge
         assign up2 = stk_ff[i];
      end
      if (i + 3 < SLOTS) begin : g_up3
         assign up3 = stk_ff[i + 3];
      end else begin : g_up3_edge
         assign up3 = stk_ff[i];
      end
      if (i == 0) begin : g_down_top
         assign down = push_val;
      end else begin : g_down
         assign down = stk_ff[i - 1];
      end
      always_comb begin
         if (push_en) begin
            stk_in[i] = down;
         end else begin
            case (pops)
               2'd1:    stk_in[i] = up1;
               2'd2:    stk_in[i] = up2;
               2'd3:    stk_in[i] = up3;
               default: stk_in[i] = stk_ff[i];
            endcase
         end
      end
   end

   assign count_in = push_en ? (count_ff + CNT_W'(1)) : (count_ff - CNT_W'(pops));

   always_ff @(posedge clock) begin
      if (fire) begin
         stk_ff <= stk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         count_ff <= '0;
         bp_ff    <= '0;
         start_ff <= '0;
         len_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         bp_ff    <= bp_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      if (pre_en) begin
         wr_out.first  = make_item(EV_VALUE, ERR_NONE, start_ff, len_ff, !main_en);
         wr_out.second = make_item(main_ev, main_err, start_ff, len_ff, 1'b1);
         wr_out.count  = main_en ? 2'd2 : 2'd1;
      end else begin
         wr_out.first  = make_item(main_ev, main_err, start_ff, len_ff, 1'b1);
         wr_out.second = wr_out.first;
         wr_out.count  = main_en ? 2'd1 : 2'd0;
      end
   end

endmodule

### rtl/jet_queue.sv
// jet_queue: small result queue that takes up to two events a cycle and drives the rsp channel
// depends on jet_pkg and jet_rsp_if
module jet_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  jet_pkg::event_pair_type wr_in,
   output logic                    room,
   jet_rsp_if.source               rsp
);
   import jet_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type     q_ff [QUEUE_DEPTH];
   rsp_item_type     head;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop;

   // room for the two events one request can cause
   assign room = cnt_ff <= CNT_W'(QUEUE_DEPTH - 2);
   assign pop  = rsp.valid && rsp.ready;
   assign head = q_ff[rd_ptr_ff];

   assign rsp.valid       = cnt_ff != '0;
   assign rsp.event_res   = head.event_res;
   assign rsp.error_kind  = head.error_kind;
   assign rsp.text_start  = head.text_start;
   assign rsp.text_length = head.text_length;
   assign rsp.last_of_run = head.last_of_run;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(wr_in.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(wr_in.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (wr_in.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= wr_in.first;
      end
      if (wr_in.count == 2'd2) begin
         q_ff[PTR_W'(wr_ptr_ff + PTR_W'(1))] <= wr_in.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### rtl/json_event_tokenizer_unit.sv
// JSON event tokenizer. Takes one byte of JSON text (or an end mark) per request and turns
// it into begin/end object, begin/end array, key, value, done and error events, one event per
// rsp handshake. A request is taken every cycle while the result queue has room for two
// events. The first event of a request passes the request register, then the result queue,
// before it shows on rsp; without room it waits in the request register. While each request
// causes at most one event and the events drain at one per cycle, the sustained rate is one
// request per cycle; a request that causes two events puts both in the queue, and the rsp
// side then sets the pace at one event per cycle. The context stack is a shift register of
// STACK_DEPTH entries (at least four), so no clearing pass is needed after reset. After
// done or error all further requests are accepted and dropped until reset.
// depends on jet_pkg, jet_req_if, jet_rsp_if, jet_core and jet_queue
module json_event_tokenizer_unit #(
   parameter int STACK_DEPTH = jet_pkg::STACK_DEPTH_DEF,
   parameter int OFFSET_BITS = jet_pkg::OFFSET_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   jet_req_if.sink  req,
   jet_rsp_if.source rsp
);
   import jet_pkg::*;

   event_pair_type wr;
   logic           room;

   jet_core #(
      .STACK_DEPTH (STACK_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .room   (room),
      .wr_out (wr)
   );

   jet_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr_in (wr),
      .room  (room),
      .rsp   (rsp)
   );

endmodule

### rtl/jet_checker.sv
// jet_checker: port-level checks on the tokenizer result channel, bound to the top level
// depends on jet_pkg
module jet_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_res,
   input logic [1:0]  rsp_error_kind,
   input logic [23:0] rsp_text_start,
   input logic [23:0] rsp_text_length,
   input logic        rsp_last_of_run
);
   import jet_pkg::*;

   // a stalled event holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res) &&
         $stable(rsp_error_kind) && $stable(rsp_text_start) && $stable(rsp_text_length))
      else $error("rsp event changed while stalled");

   // nothing follows done or error
   a_end_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_event_res == EV_DONE || rsp_event_res == EV_ERROR)
      |=> !rsp_valid)
      else $error("event after done or error");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_DONE || rsp_event_res == EV_ERROR) |-> rsp_last_of_run)
      else $error("done or error not last of run");

   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_res == EV_ERROR) == (rsp_error_kind != ERR_NONE)))
      else $error("error kind does not match event");

   a_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_KEY && rsp_event_res != EV_VALUE
      |-> rsp_text_start == '0 && rsp_text_length == '0)
      else $error("text fields set on a structural event");

endmodule

bind json_event_tokenizer_unit jet_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_event_res   (rsp.event_res),
   .rsp_error_kind  (rsp.error_kind),
   .rsp_text_start  (rsp.text_start),
   .rsp_text_length (rsp.text_length),
   .rsp_last_of_run (rsp.last_of_run)
);

### dv/tb_json_event_tokenizer_unit.sv
// tb_json_event_tokenizer_unit: self-checking bench that streams JSON text into the
// tokenizer and compares every event with a cycle-free software tokenizer
// depends on jet_pkg, jet_req_if, jet_rsp_if and json_event_tokenizer_unit
module tb_json_event_tokenizer_unit;
   import jet_pkg::*;

   localparam int STACK_LIMIT  = STACK_DEPTH_DEF;
   localparam int BODY_ITEMS   = 800;
   localparam int CALM_ITEMS   = 120;
   localparam int DRAIN_CYCLES = 16;
   localparam int LIMIT_TIME   = 3_000_000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   // the parse stops for good on done or error, so the text closes with one of these
   typedef enum {
      END_EOT, END_NUL, END_BARE_EOT, END_BARE_NUL, END_LINE_EOT, END_LINE_NUL,
      END_SLASH_EOT, END_STRING_EOT, END_ESCAPE_EOT, END_STRING_BREAK, END_BLOCK_EOT,
      END_BLOCK_NUL, END_MISMATCH, END_OVERFLOW
   } ending_type;

   logic clock;
   logic reset;

   jet_req_if req_if ();
   jet_rsp_if rsp_if ();

   json_event_tokenizer_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   text_item_type text_q [$];
   rsp_item_type  pending_events [$];
   rsp_item_type  oldest_event;
   text_item_type next_item;
   ending_type    ending;

   // tokenizer state as seen by the bench
   mode_type     scan_state;
   ctx_type      nest_ctx [STACK_LIMIT];
   int           nest_depth;
   logic [23:0]  byte_pos;
   logic [23:0]  tok_start;
   logic [23:0]  tok_len;
   rsp_item_type step_events [2];
   int           step_count;

   int  fail_count = 0;
   int  requests_taken = 0;
   int  events_checked = 0;
   int  cycle_count = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  req_fire = 1'b0;

   logic [7:0] warmup_text [26] = '{
      CH_LBRACE, CH_QUOTE, 8'h6B, CH_BACKSLASH, CH_NUL, CH_QUOTE, CH_COLON, CH_LBRACKET,
      8'hFF, CH_COMMA, CH_QUOTE, CH_BACKSLASH, CH_QUOTE, 8'h76, CH_QUOTE, CH_RBRACKET,
      CH_RBRACE, CH_SLASH, 8'h01, CH_HASH, CH_LF, CH_SLASH, CH_STAR, CH_STAR, CH_STAR,
      CH_SLASH
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- event prediction ----------------

   function automatic void emit_event(event_type ev, error_type kind, logic [23:0] start,
                                      logic [23:0] len);
      if (step_count < 2) begin
         step_events[step_count] = '{ev, kind, start, len, 1'b0};
         step_count++;
      end
   endfunction

   function automatic void stop_with(error_type kind);
      emit_event(EV_ERROR, kind, '0, '0);
      scan_state = MODE_FINISHED;
   endfunction

   function automatic void finish_text();
      emit_event(EV_DONE, ERR_NONE, '0, '0);
      scan_state = MODE_FINISHED;
   endfunction

   function automatic ctx_type top_ctx();
      return (nest_depth == 0) ? CTX_NONE : nest_ctx[nest_depth - 1];
   endfunction

   function automatic bit push_ctx(ctx_type ctx);
      if (nest_depth >= STACK_LIMIT) begin
         stop_with(ERR_OVERFLOW);
         return 1'b0;
      end
      nest_ctx[nest_depth] = ctx;
      nest_depth++;
      return 1'b1;
   endfunction

   function automatic void pop_if_value();
      if (top_ctx() == CTX_VALUE) nest_depth--;
   endfunction

   function automatic void close_ctx(ctx_type want, event_type ev);
      pop_if_value();
      if (top_ctx() != want) begin
         stop_with(ERR_MISMATCH);
      end else begin
         nest_depth--;
         emit_event(ev, ERR_NONE, '0, '0);
      end
   endfunction

   // token length saturates instead of wrapping
   function automatic void grow_len(logic [24:0] n);
      logic [24:0] sum;
      sum = {1'b0, tok_len} + n;
      tok_len = sum[24] ? {24{1'b1}} : sum[23:0];
   endfunction

   function automatic void scan_normal(logic [7:0] c);
      case (c)
         CH_NUL: finish_text();
         CH_SLASH: scan_state = MODE_SLASH;
         CH_HASH: scan_state = MODE_LINE;
         CH_LBRACE: if (push_ctx(CTX_OBJECT)) emit_event(EV_BEGIN_OBJECT, ERR_NONE, '0, '0);
         CH_LBRACKET: if (push_ctx(CTX_ARRAY)) emit_event(EV_BEGIN_ARRAY, ERR_NONE, '0, '0);
         CH_RBRACE: close_ctx(CTX_OBJECT, EV_END_OBJECT);
         CH_RBRACKET: close_ctx(CTX_ARRAY, EV_END_ARRAY);
         CH_COLON: void'(push_ctx(CTX_VALUE));
         CH_COMMA: pop_if_value();
         CH_QUOTE: begin
            tok_start = byte_pos + 24'd1;
            tok_len = '0;
            scan_state = MODE_STRING;
         end
         default: begin
            if (c > CH_SPACE) begin
               tok_start = byte_pos;
               tok_len = 24'd1;
               scan_state = MODE_BARE;
            end
         end
      endcase
   endfunction

   function automatic void scan_block(logic [7:0] c);
      if (c == CH_NUL) stop_with(ERR_UNTERMINATED);
      else if (c == CH_STAR) scan_state = MODE_BLOCK_STAR;
      else scan_state = MODE_BLOCK;
   endfunction

   function automatic void close_bare();
      emit_event(EV_VALUE, ERR_NONE, tok_start, tok_len);
      pop_if_value();
      scan_state = MODE_NORMAL;
   endfunction

   function automatic void tokenize_request(logic [7:0] c, logic eot);
      ctx_type enclosing;
      step_count = 0;
      if (scan_state == MODE_FINISHED) return;
      if (eot) begin
         case (scan_state)
            MODE_BLOCK, MODE_BLOCK_STAR, MODE_STRING, MODE_ESCAPE: stop_with(ERR_UNTERMINATED);
            MODE_BARE: begin
               close_bare();
               finish_text();
            end
            default: finish_text();
         endcase
      end else begin
         case (scan_state)
            MODE_NORMAL: scan_normal(c);
            MODE_SLASH: begin
               if (c == CH_SLASH) scan_state = MODE_LINE;
               else if (c == CH_STAR) scan_state = MODE_BLOCK;
               else begin
                  scan_state = MODE_NORMAL;
                  scan_normal(c);
               end
            end
            MODE_LINE: begin
               if (c == CH_NUL) finish_text();
               else if (c == CH_LF || c == CH_CR) scan_state = MODE_NORMAL;
            end
            MODE_BLOCK: scan_block(c);
            MODE_BLOCK_STAR: begin
               if (c == CH_SLASH) scan_state = MODE_NORMAL;
               else scan_block(c);
            end
            MODE_STRING: begin
               if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
                  stop_with(ERR_UNTERMINATED);
               end else if (c == CH_BACKSLASH) begin
                  scan_state = MODE_ESCAPE;
               end else if (c == CH_QUOTE) begin
                  enclosing = top_ctx();
                  scan_state = MODE_NORMAL;
                  // a string is a key unless an array or a value slot holds it
                  if (enclosing != CTX_ARRAY && enclosing != CTX_VALUE) begin
                     emit_event(EV_KEY, ERR_NONE, tok_start, tok_len);
                  end else begin
                     pop_if_value();
                     emit_event(EV_VALUE, ERR_NONE, tok_start, tok_len);
                  end
               end else begin
                  grow_len(25'd1);
               end
            end
            MODE_ESCAPE: begin
               grow_len(25'd2);
               scan_state = MODE_STRING;
            end
            MODE_BARE: begin
               if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACKET || c == CH_NUL
                   || c == CH_LF || c == CH_CR) begin
                  // the delimiter is scanned again, so a closer adds its own event
                  close_bare();
                  scan_normal(c);
               end else begin
                  grow_len(25'd1);
               end
            end
            default: ;
         endcase
         byte_pos = byte_pos + 24'd1;
      end
      if (step_count > 0) step_events[step_count - 1].last_of_run = 1'b1;
      for (int i = 0; i < step_count; i++) pending_events.push_back(step_events[i]);
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // ---------------- text generation ----------------

   function automatic logic [7:0] rand_byte(int lo, int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic void put_byte(logic [7:0] b);
      text_q.push_back('{text_byte: b, end_of_text: 1'b0});
   endfunction

   function automatic void put_end();
      text_q.push_back('{text_byte: rand_byte(0, 255), end_of_text: 1'b1});
   endfunction

   function automatic logic [7:0] comment_char();
      logic [7:0] c;
      do c = rand_byte(1, 255);
      while (c == CH_LF || c == CH_CR);
      return c;
   endfunction

   function automatic void open_string();
      logic [7:0] c;
      int len;
      put_byte(CH_QUOTE);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      repeat (len) begin
         if ($urandom_range(0, 5) == 0) begin
            // any byte may follow a backslash, NUL and line breaks included
            put_byte(CH_BACKSLASH);
            put_byte(rand_byte(0, 255));
         end else begin
            do c = rand_byte(1, 255);
            while (c == CH_LF || c == CH_CR || c == CH_QUOTE || c == CH_BACKSLASH);
            put_byte(c);
         end
      end
   endfunction

   function automatic void gen_string();
      open_string();
      put_byte(CH_QUOTE);
   endfunction

   function automatic void gen_bare();
      logic [7:0] c;
      do c = rand_byte(33, 255);
      while (c == CH_SLASH || c == CH_HASH || c == CH_LBRACE || c == CH_LBRACKET
             || c == CH_RBRACE || c == CH_RBRACKET || c == CH_COLON || c == CH_COMMA
             || c == CH_QUOTE);
      put_byte(c);
      repeat ($urandom_range(0, 5)) begin
         do c = rand_byte(1, 255);
         while (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACKET || c == CH_LF
                || c == CH_CR);
         put_byte(c);
      end
   endfunction

   // whitespace, comments and lone slashes that leave the scanner where it was
   function automatic void gen_gap();
      int len;
      bit prev_star;
      logic [7:0] c;
      repeat ($urandom_range(0, 2)) begin
         len = $urandom_range(0, 5);
         case ($urandom_range(0, 5))
            0, 1, 2: repeat (len + 1) put_byte(rand_byte(1, 32));
            3: begin
               if ($urandom_range(0, 1) == 0) begin
                  put_byte(CH_HASH);
               end else begin
                  put_byte(CH_SLASH);
                  put_byte(CH_SLASH);
               end
               repeat (len) put_byte(comment_char());
               put_byte(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
            end
            4: begin
               put_byte(CH_SLASH);
               put_byte(CH_STAR);
               prev_star = 1'b0;
               repeat (len) begin
                  c = rand_byte(1, 255);
                  if (prev_star && c == CH_SLASH) c = CH_STAR;
                  prev_star = (c == CH_STAR);
                  put_byte(c);
               end
               put_byte(CH_STAR);
               put_byte(CH_SLASH);
            end
            default: begin
               put_byte(CH_SLASH);
               put_byte(rand_byte(1, 32));
            end
         endcase
      end
   endfunction

   // a bare value must meet its delimiter right away, whitespace would extend it
   function automatic void after_value(bit bare, bit at_top);
      if (bare) begin
         if (at_top) begin
            case ($urandom_range(0, 2))
               0: put_byte(CH_LF);
               1: put_byte(CH_CR);
               default: put_byte(CH_COMMA);
            endcase
         end else if ($urandom_range(0, 2) == 0) begin
            put_byte(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR);
         end else begin
            return;
         end
      end
      gen_gap();
   endfunction

   function automatic bit gen_value(int depth);
      int pick;
      pick = $urandom_range(0, 9);
      if (depth < 4 && pick < 2) begin
         gen_object(depth + 1);
         return 1'b0;
      end
      if (depth < 4 && pick < 4) begin
         gen_array(depth + 1);
         return 1'b0;
      end
      if (pick < 7) begin
         gen_string();
         return 1'b0;
      end
      gen_bare();
      return 1'b1;
   endfunction

   function automatic void gen_object(int depth);
      int members;
      put_byte(CH_LBRACE);
      gen_gap();
      members = $urandom_range(0, 3);
      for (int i = 0; i < members; i++) begin
         if (i > 0) begin
            put_byte(CH_COMMA);
            gen_gap();
         end
         gen_string();
         gen_gap();
         put_byte(CH_COLON);
         gen_gap();
         after_value(gen_value(depth), 1'b0);
      end
      put_byte(CH_RBRACE);
   endfunction

   function automatic void gen_array(int depth);
      int elements;
      put_byte(CH_LBRACKET);
      gen_gap();
      elements = $urandom_range(0, 3);
      for (int i = 0; i < elements; i++) begin
         if (i > 0) begin
            put_byte(CH_COMMA);
            gen_gap();
         end
         after_value(gen_value(depth), 1'b0);
      end
      put_byte(CH_RBRACKET);
   endfunction

   function automatic bit idling_allowed();
      return (cycle_count % 200) >= 60 && text_q.size() > CALM_ITEMS;
   endfunction

   // ---------------- stimulus and end of run ----------------

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.text_byte = '0;
      req_if.end_of_text = 1'b0;
      rsp_if.ready = 1'b0;

      foreach (warmup_text[i]) put_byte(warmup_text[i]);

      while (text_q.size() < BODY_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: gen_object(1);
            4, 5, 6: gen_array(1);
            7: after_value(gen_value(0), 1'b1);
            default: begin
               // malformed but harmless sequences
               case ($urandom_range(0, 4))
                  0: begin
                     put_byte(CH_LBRACE);
                     gen_string();
                     put_byte(CH_COLON);
                     put_byte(CH_RBRACE);
                  end
                  1: begin
                     put_byte(CH_LBRACKET);
                     put_byte(CH_COLON);
                     gen_string();
                     put_byte(CH_RBRACKET);
                  end
                  2: begin
                     put_byte(CH_COLON);
                     put_byte(CH_COMMA);
                  end
                  3: begin
                     put_byte(CH_COLON);
                     gen_string();
                  end
                  default: begin
                     put_byte(CH_LBRACE);
                     put_byte(CH_COMMA);
                     gen_string();
                     put_byte(CH_COMMA);
                     put_byte(CH_RBRACE);
                  end
               endcase
            end
         endcase
         gen_gap();
      end

      ending = ending_type'($urandom_range(0, END_OVERFLOW));
      if (ending < END_MISMATCH) repeat ($urandom_range(0, 2)) put_byte(CH_LBRACKET);
      case (ending)
         END_EOT: put_end();
         END_NUL: put_byte(CH_NUL);
         END_BARE_EOT: begin
            gen_bare();
            put_end();
         end
         END_BARE_NUL: begin
            gen_bare();
            put_byte(CH_NUL);
         end
         END_LINE_EOT: begin
            put_byte(CH_HASH);
            put_byte(comment_char());
            put_end();
         end
         END_LINE_NUL: begin
            put_byte(CH_SLASH);
            put_byte(CH_SLASH);
            put_byte(comment_char());
            put_byte(CH_NUL);
         end
         END_SLASH_EOT: begin
            put_byte(CH_SLASH);
            put_end();
         end
         END_STRING_EOT: begin
            open_string();
            put_end();
         end
         END_ESCAPE_EOT: begin
            open_string();
            put_byte(CH_BACKSLASH);
            put_end();
         end
         END_STRING_BREAK: begin
            open_string();
            case ($urandom_range(0, 2))
               0: put_byte(CH_NUL);
               1: put_byte(CH_LF);
               default: put_byte(CH_CR);
            endcase
         end
         END_BLOCK_EOT, END_BLOCK_NUL: begin
            put_byte(CH_SLASH);
            put_byte(CH_STAR);
            put_byte(comment_char());
            if ($urandom_range(0, 1) == 0) put_byte(CH_STAR);
            if (ending == END_BLOCK_EOT) put_end();
            else put_byte(CH_NUL);
         end
         END_MISMATCH: begin
            case ($urandom_range(0, 3))
               0: put_byte(CH_RBRACE);
               1: put_byte(CH_RBRACKET);
               2: begin
                  put_byte(CH_LBRACKET);
                  put_byte(CH_RBRACE);
               end
               default: begin
                  put_byte(CH_LBRACE);
                  gen_string();
                  put_byte(CH_COLON);
                  put_byte(CH_RBRACKET);
               end
            endcase
         end
         default: begin
            repeat (STACK_LIMIT + 1) begin
               case ($urandom_range(0, 2))
                  0: put_byte(CH_LBRACE);
                  1: put_byte(CH_LBRACKET);
                  default: put_byte(CH_COLON);
               endcase
            end
         end
      endcase
      // the block must swallow whatever follows the end of the parse
      repeat ($urandom_range(2, 5)) begin
         text_q.push_back('{text_byte: rand_byte(0, 255),
                            end_of_text: 1'($urandom_range(0, 1))});
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_q.size() != 0 || req_if.valid) @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests tokenized into %0d checked events", requests_taken,
               events_checked);
      $display("text closed by %s after warmup, documents, comments and noise",
               ending.name());
      if (fail_count == 0) begin
         $display("json_event_tokenizer_unit verification clean");
      end else begin
         $display("json_event_tokenizer_unit verification failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_TIME);
      $error("run did not drain in time, %0d events still expected", pending_events.size());
      $display("json_event_tokenizer_unit verification failed");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_fire || !req_if.valid) begin
         if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (text_q.size() != 0) begin
            next_item = text_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.text_byte <= next_item.text_byte;
            req_if.end_of_text <= next_item.end_of_text;
            if (idling_allowed() && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 8);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // event sink with random back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (idling_allowed() && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 8);
      end
   end

   // monitor: predict on each request, check each event against the oldest prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (reset) begin
         scan_state = MODE_NORMAL;
         nest_depth = 0;
         byte_pos = '0;
         tok_start = '0;
         tok_len = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            requests_taken++;
            tokenize_request(req_if.text_byte, req_if.end_of_text);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            events_checked++;
            if (pending_events.size() == 0) begin
               $error("event_res arrived with nothing expected: expected none, got %0d",
                      rsp_if.event_res);
               fail_count++;
            end else begin
               oldest_event = pending_events.pop_front();
               check_field("event_res", 24'(oldest_event.event_res), 24'(rsp_if.event_res));
               check_field("error_kind", 24'(oldest_event.error_kind),
                           24'(rsp_if.error_kind));
               check_field("text_start", oldest_event.text_start, rsp_if.text_start);
               check_field("text_length", oldest_event.text_length, rsp_if.text_length);
               check_field("last_of_run", 24'(oldest_event.last_of_run),
                           24'(rsp_if.last_of_run));
            end
         end
      end
   end

endmodule

### json_event_tokenizer_unit.f
rtl/jet_pkg.sv
rtl/jet_req_if.sv
rtl/jet_rsp_if.sv
rtl/jet_core.sv
rtl/jet_queue.sv
rtl/json_event_tokenizer_unit.sv
rtl/jet_checker.sv
dv/tb_json_event_tokenizer_unit.sv
